// ===== sv/oil_paint_window_filter_defines.svh =====
// Assertion macros used by the oil-paint window filter checker.
`ifndef OIL_PAINT_WINDOW_FILTER_DEFINES_SVH
`define OIL_PAINT_WINDOW_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define OPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define OPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/opw_pkg.sv =====
// Types and constants of the oil-paint window filter.
`default_nettype none
package opw_pkg;

  localparam int CH_W = 8;
  localparam int PW = 10;
  localparam int LUM_MAX = 765;
  localparam int RECIP = 5482;
  localparam int RECIP_SHIFT = 22;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_LEVELS = 2'd3;

  localparam logic [8:0] RST_WIDTH = 9'd256;
  localparam logic [8:0] RST_HEIGHT = 9'd256;
  localparam logic [3:0] RST_RADIUS = 4'd5;
  localparam logic [4:0] RST_LEVELS = 5'd20;

  typedef struct packed {
    logic       op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
  } in_item_t;

  typedef struct packed {
    logic [7:0] res_col;
    logic [7:0] res_row;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
  } out_item_t;

  typedef struct packed {
    logic [7:0] c;
    logic [7:0] b;
    logic [7:0] a;
  } pix_t;

endpackage
`default_nettype wire

// ===== sv/oil_paint_window_filter.sv =====
// Oil-paint window filter over a stored three-channel frame.
// Store transaction: the next transaction may follow at once.
// Filter transaction: window scan over the N clipped window pixels (one frame
//   RAM read per cycle), then three serial divisions, then the result; off-image pixels skip to it.
// Reset: registers return to 256, 256, 5, 20; frame contents stay undefined until written.
`default_nettype none
module oil_paint_window_filter #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 15,
  parameter int MAX_BINS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire opw_pkg::in_item_t   in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output opw_pkg::out_item_t       out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import opw_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int CNT_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W = CNT_W + CH_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_DSTART = 3'd3;
  localparam logic [2:0] ST_DWAIT  = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [8:0] cfg_w_q, cfg_h_q;
  logic [3:0] cfg_r_q;
  logic [4:0] cfg_l_q;
  logic [8:0] w_eff, h_eff;
  logic [5:0] r_eff;
  logic [7:0] lv_eff;

  logic [2:0] state_q;
  logic [PW-1:0] x_q, y_q, x1_q, y0_q, y1_q;
  logic [PW-1:0] x0_d, x1_d, y0_d, y1_d;
  logic [7:0] col_q, row_q;
  logic [1:0] div_idx_q;
  logic [2:0][7:0] res_q;
  logic pv0_q;
  logic out_valid_q;
  out_item_t out_q;

  logic accept, in_img, in_frame, load_out;
  logic [PW-1:0] colx, rowx, rx, wm1, hm1, sumx, sumy;
  logic [AW-1:0] rd_addr, wr_addr, ram_addr;
  logic ram_we;
  pix_t ram_wdata, ram_rdata;

  logic hist_busy;
  logic [CNT_W-1:0] best_cnt;
  logic [2:0][SUM_W-1:0] best_sum;
  logic div_start, div_done;
  logic [SUM_W-1:0] div_quot;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = 9'd1;
    end else if (32'(cfg_w_q) > MAX_WIDTH) begin
      w_eff = 9'(MAX_WIDTH);
    end else begin
      w_eff = cfg_w_q;
    end
    if (cfg_h_q == '0) begin
      h_eff = 9'd1;
    end else if (32'(cfg_h_q) > MAX_HEIGHT) begin
      h_eff = 9'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_q;
    end
    r_eff = (32'(cfg_r_q) > MAX_RADIUS) ? 6'(MAX_RADIUS) : 6'(cfg_r_q);
    lv_eff = (32'(cfg_l_q) > MAX_BINS - 1) ? 8'(MAX_BINS - 1) : 8'(cfg_l_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= RST_WIDTH;
      cfg_h_q <= RST_HEIGHT;
      cfg_r_q <= RST_RADIUS;
      cfg_l_q <= RST_LEVELS;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  cfg_w_q <= pwdata[8:0];
        REG_HEIGHT: cfg_h_q <= pwdata[8:0];
        REG_RADIUS: cfg_r_q <= pwdata[3:0];
        REG_LEVELS: cfg_l_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(cfg_w_q);
      REG_HEIGHT: prdata = 32'(cfg_h_q);
      REG_RADIUS: prdata = 32'(cfg_r_q);
      REG_LEVELS: prdata = 32'(cfg_l_q);
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_comb begin
    colx = PW'(in_data_i.col);
    rowx = PW'(in_data_i.row);
    rx = PW'(r_eff);
    wm1 = PW'(w_eff) - PW'(1);
    hm1 = PW'(h_eff) - PW'(1);
    sumx = colx + rx;
    sumy = rowx + rx;
    x0_d = (colx > rx) ? colx - rx : '0;
    y0_d = (rowx > rx) ? rowx - rx : '0;
    x1_d = (sumx < wm1) ? sumx : wm1;
    y1_d = (sumy < hm1) ? sumy : hm1;
    in_img = (9'(in_data_i.col) < w_eff) && (9'(in_data_i.row) < h_eff);
    in_frame = (32'(in_data_i.col) < MAX_WIDTH) && (32'(in_data_i.row) < MAX_HEIGHT);
    rd_addr = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
    wr_addr = AW'(32'(in_data_i.row) * MAX_WIDTH + 32'(in_data_i.col));
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i && !in_stall_o;
  assign ram_we = accept && (in_data_i.op == OP_STORE) && in_frame;
  assign ram_addr = (state_q == ST_SCAN) ? rd_addr : wr_addr;
  assign ram_wdata = '{c: in_data_i.chan_c, b: in_data_i.chan_b, a: in_data_i.chan_a};
  assign div_start = (state_q == ST_DSTART);
  assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  opw_ram #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  opw_hist #(
    .MAX_BINS (MAX_BINS),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_hist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (accept && (in_data_i.op == OP_FILTER)),
    .lv_i        (lv_eff),
    .pix_valid_i (pv0_q),
    .pix_i       (ram_rdata),
    .busy_o      (hist_busy),
    .best_cnt_o  (best_cnt),
    .best_sum_o  (best_sum)
  );

  opw_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (best_sum[div_idx_q]),
    .divisor_i  (best_cnt),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pv0_q <= 1'b0;
      div_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pv0_q <= (state_q == ST_SCAN);
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (in_data_i.op == OP_FILTER)) begin
            state_q <= in_img ? ST_SCAN : ST_FIN;
          end
        end
        ST_SCAN: begin
          if ((y_q == y1_q) && (x_q == x1_q)) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pv0_q && !hist_busy) begin
            div_idx_q <= '0;
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            if (div_idx_q == 2'd2) begin
              state_q <= ST_FIN;
            end else begin
              div_idx_q <= div_idx_q + 2'd1;
              state_q <= ST_DSTART;
            end
          end
        end
        ST_FIN: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.op == OP_FILTER)) begin
      col_q <= in_data_i.col;
      row_q <= in_data_i.row;
      x1_q <= x1_d;
      y0_q <= y0_d;
      y1_q <= y1_d;
      x_q <= x0_d;
      y_q <= y0_d;
      res_q <= '0;
    end else if (state_q == ST_SCAN) begin
      if (y_q == y1_q) begin
        y_q <= y0_q;
        x_q <= x_q + PW'(1);
      end else begin
        y_q <= y_q + PW'(1);
      end
    end else if ((state_q == ST_DWAIT) && div_done) begin
      res_q[div_idx_q] <= div_quot[7:0];
    end
    if (load_out) begin
      out_q <= '{res_col: col_q, res_row: row_q,
                 out_a: res_q[0], out_b: res_q[1], out_c: res_q[2]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ===== sv/opw_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module opw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/opw_hist.sv =====
// Intensity binning pipeline and per-bin count and channel sums.
`default_nettype none
module opw_hist #(
  parameter int MAX_BINS = 32,
  parameter int CNT_W = 10,
  parameter int SUM_W = 18
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic [7:0]                lv_i,
  input  wire logic                      pix_valid_i,
  input  wire opw_pkg::pix_t             pix_i,
  output logic                           busy_o,
  output logic [CNT_W-1:0]               best_cnt_o,
  output logic [2:0][SUM_W-1:0]          best_sum_o
);
  import opw_pkg::*;

  localparam int BW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic        pv1_q, pv2_q, pv3_q;
  logic [17:0] prod1_q, prod2_q;
  pix_t        pix1_q, pix2_q, pix3_q;
  logic [8:0]  q0_q;
  logic [BW-1:0] bin3_q;

  logic [9:0]  lum;
  logic [30:0] scaled;
  logic [19:0] rem;
  logic [8:0]  binc;
  logic [BW-1:0] bin_d;

  logic [CNT_W-1:0] cnt_q [MAX_BINS];
  logic [SUM_W-1:0] sa_q [MAX_BINS];
  logic [SUM_W-1:0] sb_q [MAX_BINS];
  logic [SUM_W-1:0] sc_q [MAX_BINS];
  logic [CNT_W-1:0] best_q;
  logic [BW-1:0]    best_bin_q;
  logic [CNT_W-1:0] cnt_new;

  always_comb begin
    lum = 10'(pix_i.a) + 10'(pix_i.b) + 10'(pix_i.c);
    scaled = 31'(prod1_q) * 31'(RECIP);
    rem = 20'(prod2_q) - 20'(q0_q) * 20'(LUM_MAX);
    binc = (rem >= 20'(LUM_MAX)) ? q0_q + 9'd1 : q0_q;
    if (32'(binc) > MAX_BINS - 1) begin
      bin_d = BW'(MAX_BINS - 1);
    end else begin
      bin_d = BW'(binc);
    end
    cnt_new = cnt_q[bin3_q] + CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv1_q <= 1'b0;
      pv2_q <= 1'b0;
      pv3_q <= 1'b0;
    end else begin
      pv1_q <= pix_valid_i;
      pv2_q <= pv1_q;
      pv3_q <= pv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= 18'(lum) * 18'(lv_i);
    pix1_q  <= pix_i;
    q0_q    <= 9'(scaled >> RECIP_SHIFT);
    prod2_q <= prod1_q;
    pix2_q  <= pix1_q;
    bin3_q  <= bin_d;
    pix3_q  <= pix2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      best_bin_q <= '0;
      for (int i = 0; i < MAX_BINS; i++) begin
        cnt_q[i] <= '0;
        sa_q[i] <= '0;
        sb_q[i] <= '0;
        sc_q[i] <= '0;
      end
    end else if (clear_i) begin
      best_q <= '0;
      best_bin_q <= '0;
      for (int i = 0; i < MAX_BINS; i++) begin
        cnt_q[i] <= '0;
        sa_q[i] <= '0;
        sb_q[i] <= '0;
        sc_q[i] <= '0;
      end
    end else if (pv3_q) begin
      cnt_q[bin3_q] <= cnt_new;
      sa_q[bin3_q] <= sa_q[bin3_q] + SUM_W'(pix3_q.a);
      sb_q[bin3_q] <= sb_q[bin3_q] + SUM_W'(pix3_q.b);
      sc_q[bin3_q] <= sc_q[bin3_q] + SUM_W'(pix3_q.c);
      if (cnt_new > best_q) begin
        best_q <= cnt_new;
        best_bin_q <= bin3_q;
      end
    end
  end

  assign busy_o = pv1_q | pv2_q | pv3_q;
  assign best_cnt_o = best_q;
  assign best_sum_o[0] = sa_q[best_bin_q];
  assign best_sum_o[1] = sb_q[best_bin_q];
  assign best_sum_o[2] = sc_q[best_bin_q];

endmodule
`default_nettype wire

// ===== sv/opw_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module opw_div #(
  parameter int DIVIDEND_W = 18,
  parameter int DIVISOR_W = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quot_o
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CW-1:0]         cnt_q;
  logic [DIVIDEND_W-1:0] quot_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    trial;
  logic                  take;

  always_comb begin
    trial = {rem_q, quot_q[DIVIDEND_W-1]};
    take = (trial >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CW'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIVIDEND_W-2:0], take};
      rem_q <= take ? DIVISOR_W'(trial - {1'b0, dvs_q}) : DIVISOR_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// ===== sv/opw_checker.sv =====
// Port-level checks of the oil-paint window filter and their binding.
`default_nettype none
`include "oil_paint_window_filter_defines.svh"
module opw_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire opw_pkg::in_item_t in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i
);
  import opw_pkg::*;

  `OPW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `OPW_ASSERT_NEXT(a_filter_busy, in_valid_i && !in_stall_o && (in_data_i.op == OP_FILTER), in_stall_o, "filter transaction did not hold input")
  `OPW_ASSERT_NEXT(a_no_spurious, !out_valid_o && !in_stall_o, !out_valid_o, "result without filter transaction")

endmodule

bind oil_paint_window_filter opw_checker u_opw_checker (.*);
`default_nettype wire
